// ----- sv/fpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_SAT = 2'd1, ST_DIV0 = 2'd2
  } status_t;

  localparam int DATA_W = 32;
endpackage
`default_nettype wire

// ----- sv/fpa_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_raw;
  logic               compare_true;
  logic [1:0]         status;
  modport source (output valid, result_raw, compare_true, status, input ready);
  modport sink (input valid, result_raw, compare_true, status, output ready);
endinterface
`default_nettype wire

// ----- sv/fixed_point_alu_top.sv -----
// Throughput: one item per cycle while the output is not stalled; all stages advance together on a global enable.
// The divider is a restoring array with one quotient bit per pipeline stage.
// Stalls hold every stage in place; outside reset, the input stays ready while the output stage is free or being read.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_top import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input wire logic clk,
  input wire logic rst,
  fpa_in_if.sink   in_ch,
  fpa_out_if.source out_ch
);
  localparam int NW  = DATA_W + FRAC_BITS;   // divide numerator width
  localparam int PW  = 2 * DATA_W;           // product magnitude width
  localparam int NS  = NW + 3;               // stage count
  localparam int QW  = NW + 1;

  typedef struct packed {
    logic [3:0]    mode;
    logic          neg;
    logic          bzero;
    logic [31:0]   simple;
    logic          cmp;
    logic          sat;
    logic [PW-1:0] mag;     // product magnitude
    logic [NW-1:0] num;     // shifts left; quotient bits enter at the bottom
    logic [32:0]   rem;
    logic [31:0]   den;
  } stage_t;

  stage_t     pipe  [NS];
  logic [NS-1:0] vld;
  logic       adv;

  assign adv = !vld[NS-1] || out_ch.ready;
  assign in_ch.ready = adv && !rst;

  // front: simple ops and operand preparation
  stage_t f;
  logic signed [33:0] sum;
  logic signed [63:0] shl;
  logic [31:0] aa, ab;
  always_comb begin
    f = '0;
    f.mode = in_ch.mode;
    aa = in_ch.operand_a[31] ? 32'(-in_ch.operand_a) : in_ch.operand_a;
    ab = in_ch.operand_b[31] ? 32'(-in_ch.operand_b) : in_ch.operand_b;
    f.bzero = (in_ch.operand_b == 0);
    f.neg = in_ch.operand_a[31] ^ in_ch.operand_b[31];
    f.num = NW'(aa) << FRAC_BITS;
    f.den = ab;
    sum = '0;
    shl = 64'(in_ch.operand_a) <<< FRAC_BITS;
    unique case (mode_t'(in_ch.mode))
      OP_ADD:  sum = 34'(in_ch.operand_a) + 34'(in_ch.operand_b);
      OP_SUB:  sum = 34'(in_ch.operand_a) - 34'(in_ch.operand_b);
      OP_INC:  sum = 34'(in_ch.operand_a) + 34'sd1;
      OP_DEC:  sum = 34'(in_ch.operand_a) - 34'sd1;
      default: sum = '0;
    endcase
    unique case (mode_t'(in_ch.mode))
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (sum > 34'sh7FFFFFFF) begin
          f.simple = 32'h7FFFFFFF; f.sat = 1'b1;
        end else if (sum < -34'sh80000000) begin
          f.simple = 32'h80000000; f.sat = 1'b1;
        end else begin
          f.simple = sum[31:0];
        end
      end
      OP_FROM_INT: begin
        if (shl > 64'sh7FFFFFFF) begin
          f.simple = 32'h7FFFFFFF; f.sat = 1'b1;
        end else if (shl < -64'sh80000000) begin
          f.simple = 32'h80000000; f.sat = 1'b1;
        end else begin
          f.simple = shl[31:0];
        end
      end
      OP_TO_INT: f.simple = 32'(in_ch.operand_a >>> FRAC_BITS);
      OP_GT:   f.cmp = in_ch.operand_a > in_ch.operand_b;
      OP_LT:   f.cmp = in_ch.operand_a < in_ch.operand_b;
      OP_GE:   f.cmp = in_ch.operand_a >= in_ch.operand_b;
      OP_LE:   f.cmp = in_ch.operand_a <= in_ch.operand_b;
      OP_EQ:   f.cmp = in_ch.operand_a == in_ch.operand_b;
      OP_NE:   f.cmp = in_ch.operand_a != in_ch.operand_b;
      OP_MIN:  f.simple = (in_ch.operand_a < in_ch.operand_b) ? in_ch.operand_a
                                                             : in_ch.operand_b;
      OP_MAX:  f.simple = (in_ch.operand_a > in_ch.operand_b) ? in_ch.operand_a
                                                             : in_ch.operand_b;
      default: f.simple = '0;
    endcase
  end

  // stage 1: multiply magnitudes (aa*ab computed from stage 0 num/den)
  stage_t m;
  always_comb begin
    m = pipe[0];
    m.mag = PW'(pipe[0].num >> FRAC_BITS) * PW'(pipe[0].den);
  end

  // divider steps
  stage_t d [NW];
  logic [33:0] trial [NW];
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      d[i] = pipe[i+1];
      trial[i] = {pipe[i+1].rem, pipe[i+1].num[NW-1]} - {2'b00, pipe[i+1].den};
      if (!trial[i][33]) begin
        d[i].rem = trial[i][32:0];
        d[i].num = {pipe[i+1].num[NW-2:0], 1'b1};
      end else begin
        d[i].rem = {pipe[i+1].rem[31:0], pipe[i+1].num[NW-1]};
        d[i].num = {pipe[i+1].num[NW-2:0], 1'b0};
      end
    end
  end

  // final: rounding, saturation and the divide-by-zero result
  stage_t  l;
  logic [QW-1:0] q;
  logic [PW-1:0] pm;
  logic [PW-1:0] mg;
  logic [33:0]   r2;
  always_comb begin
    l = pipe[NS-2];
    r2 = {pipe[NS-2].rem, 1'b0};
    q = QW'(pipe[NS-2].num) + QW'(r2 >= 34'(pipe[NS-2].den));
    pm = (pipe[NS-2].mag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    mg = (mode_t'(pipe[NS-2].mode) == OP_MUL) ? pm : PW'(q);
    if (mode_t'(pipe[NS-2].mode) == OP_MUL || mode_t'(pipe[NS-2].mode) == OP_DIV) begin
      l.sat = 1'b0;
      if (pipe[NS-2].neg && mg != 0) begin
        if (mg > PW'(33'h80000000)) begin
          l.simple = 32'h80000000; l.sat = 1'b1;
        end else begin
          l.simple = 32'(-mg);
        end
      end else if (mg > PW'(32'h7FFFFFFF)) begin
        l.simple = 32'h7FFFFFFF; l.sat = 1'b1;
      end else begin
        l.simple = mg[31:0];
      end
      if (mode_t'(pipe[NS-2].mode) == OP_DIV && pipe[NS-2].bzero) begin
        l.simple = '0; l.sat = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= f;
      pipe[1] <= m;
      for (int i = 0; i < NW; i++) pipe[i+2] <= d[i];
      pipe[NS-1] <= l;
    end
  end

  assign out_ch.valid        = vld[NS-1];
  assign out_ch.result_raw   = pipe[NS-1].simple;
  assign out_ch.compare_true = pipe[NS-1].cmp;
  assign out_ch.status = (mode_t'(pipe[NS-1].mode) == OP_DIV && pipe[NS-1].bzero) ? ST_DIV0 :
                         pipe[NS-1].sat ? ST_SAT : ST_OK;
endmodule
`default_nettype wire

// ----- sv/fpa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fpa_checker import fpa_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] result_raw,
  input wire logic        compare_true,
  input wire logic [1:0]  status
);
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_SAT || status == ST_DIV0)
    else $error("bad status");
  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> result_raw == 0 && status == ST_OK)
    else $error("comparison with result");
  a_div0: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DIV0 |-> result_raw == 0 && !compare_true)
    else $error("div0 result");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("stalled with empty output");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_raw))
    else $error("output dropped");
endmodule

bind fixed_point_alu_top fpa_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .result_raw(out_ch.result_raw), .compare_true(out_ch.compare_true),
  .status(out_ch.status)
);
`default_nettype wire
